// File: sv/atfc_pkg.sv
// atfc_pkg: shared types, widths, defaults and register codes of the frequency counter
`default_nettype none

package atfc_pkg;

    // default sizing
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int HYST_SHIFT_DEF  = 3;

    // fixed field widths
    localparam int CNT_W        = 16;
    localparam int MIN_SPAN_W   = 10;
    localparam int HYST_FLOOR_W = 9;
    localparam int HZ_W         = 16;
    localparam int FREQ_W       = 32;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;

    // register defaults after reset
    localparam logic [CNT_W-1:0]        CAL_SAMPLES_RST  = 16'd200;
    localparam logic [CNT_W-1:0]        MEAS_SAMPLES_RST = 16'd800;
    localparam logic [MIN_SPAN_W-1:0]   MIN_SPAN_RST     = 10'd10;
    localparam logic [HYST_FLOOR_W-1:0] HYST_FLOOR_RST   = 9'd2;
    localparam logic [HZ_W-1:0]         HZ_PER_EDGE_RST  = 16'd200;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_SAMPLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HZ_PER_EDGE  = 3'd4;

    // operating phase
    typedef enum logic [1:0] {
        PH_CAL  = 2'd0,
        PH_INIT = 2'd1,
        PH_MEAS = 2'd2
    } t_phase;

    // configuration register bank as seen by the core
    typedef struct packed {
        logic [CNT_W-1:0]        cal_samples;
        logic [CNT_W-1:0]        meas_samples;
        logic [MIN_SPAN_W-1:0]   min_span;
        logic [HYST_FLOOR_W-1:0] hyst_floor;
        logic [HZ_W-1:0]         hz_per_edge_q4;
    } t_cfg;

    // hysteresis half-width size: enough for the span shift and the floor
    function automatic int hyst_width(input int sample_bits);
        return (sample_bits > HYST_FLOOR_W) ? sample_bits : HYST_FLOOR_W;
    endfunction

    // threshold size: midpoint plus hysteresis without overflow
    function automatic int thr_width(input int sample_bits);
        return hyst_width(sample_bits) + 1;
    endfunction

    // span compare size
    function automatic int span_cmp_width(input int sample_bits);
        return (sample_bits > MIN_SPAN_W) ? sample_bits : MIN_SPAN_W;
    endfunction

endpackage

`default_nettype wire

// File: sv/atfc_thresh.sv
// atfc_thresh: span check, midpoint and hysteresis thresholds from the tracked min and max
`default_nettype none

module atfc_thresh #(
    parameter int SAMPLE_BITS = atfc_pkg::SAMPLE_BITS_DEF,
    parameter int HYST_SHIFT  = atfc_pkg::HYST_SHIFT_DEF
) (
    input  wire logic [SAMPLE_BITS-1:0]                    i_min,
    input  wire logic [SAMPLE_BITS-1:0]                    i_max,
    input  wire logic [atfc_pkg::MIN_SPAN_W-1:0]           i_min_span,
    input  wire logic [atfc_pkg::HYST_FLOOR_W-1:0]         i_hyst_floor,
    output logic      [SAMPLE_BITS-1:0]                    o_span,
    output logic                                           o_no_signal,
    output logic      [atfc_pkg::thr_width(SAMPLE_BITS)-1:0] o_upper,
    output logic      [atfc_pkg::thr_width(SAMPLE_BITS)-1:0] o_lower
);
    import atfc_pkg::*;

    localparam int HW = hyst_width(SAMPLE_BITS);
    localparam int TW = thr_width(SAMPLE_BITS);
    localparam int CW = span_cmp_width(SAMPLE_BITS);

    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] hyst_shr;
    logic [HW-1:0]          hyst;
    logic [TW-1:0]          mid_t;
    logic [TW-1:0]          hyst_t;

    // span and no-signal test
    always_comb begin
        o_span      = i_max - i_min;
        o_no_signal = CW'(o_span) < CW'(i_min_span);
    end

    // center and half-width, floor applied
    always_comb begin
        sum      = {1'b0, i_min} + {1'b0, i_max};
        mid      = sum[SAMPLE_BITS:1];
        hyst_shr = o_span >> HYST_SHIFT;
        if (HW'(hyst_shr) < HW'(i_hyst_floor)) begin
            hyst = HW'(i_hyst_floor);
        end else begin
            hyst = HW'(hyst_shr);
        end
        mid_t  = TW'(mid);
        hyst_t = TW'(hyst);
    end

    // thresholds, lower one clamped at zero
    always_comb begin
        o_upper = mid_t + hyst_t;
        if (mid_t > hyst_t) begin
            o_lower = mid_t - hyst_t;
        end else begin
            o_lower = '0;
        end
    end

endmodule

`default_nettype wire

// File: sv/atfc_core.sv
// atfc_core: phase sequencer, window counter, edge tally and result register
`default_nettype none

module atfc_core #(
    parameter int SAMPLE_BITS = atfc_pkg::SAMPLE_BITS_DEF,
    parameter int HYST_SHIFT  = atfc_pkg::HYST_SHIFT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire atfc_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_in_valid,
    input  wire logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                                   o_in_take,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_status,
    output logic      [atfc_pkg::CNT_W-1:0]        o_edge_count,
    output logic      [atfc_pkg::FREQ_W-1:0]       o_freq_q4,
    output logic      [SAMPLE_BITS-1:0]            o_span_seen
);
    import atfc_pkg::*;

    localparam int TW = thr_width(SAMPLE_BITS);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [CNT_W-1:0] TALLY_MAX = {CNT_W{1'b1}};

    // state
    t_phase                 r_phase, n_phase;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0] r_max, n_max;
    logic [TW-1:0]          r_upper, n_upper;
    logic [TW-1:0]          r_lower, n_lower;
    logic                   r_below, n_below;
    logic [CNT_W-1:0]       r_tally, n_tally;

    // result register
    logic                   r_out_valid;
    logic                   r_out_status;
    logic [CNT_W-1:0]       r_out_count;
    logic [FREQ_W-1:0]      r_out_freq;
    logic [SAMPLE_BITS-1:0] r_out_span;

    // step signals
    logic [SAMPLE_BITS-1:0] trk_min, trk_max;
    logic [SAMPLE_BITS-1:0] thr_span;
    logic                   thr_no_sig;
    logic [TW-1:0]          thr_upper, thr_lower;
    logic [TW-1:0]          v_t;
    logic [CNT_W-1:0]       cnt_inc, lim_sel, lim;
    logic                   win_done;
    logic                   res_now;
    logic                   res_status;
    logic [CNT_W-1:0]       res_count;
    logic [FREQ_W-1:0]      res_freq;
    logic                   out_free;

    // running min and max, tracked only while calibrating
    always_comb begin
        trk_min = r_min;
        trk_max = r_max;
        if (r_phase != PH_INIT && r_phase != PH_MEAS) begin
            if (i_sample < r_min) begin
                trk_min = i_sample;
            end
            if (i_sample > r_max) begin
                trk_max = i_sample;
            end
        end
    end

    atfc_thresh #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .HYST_SHIFT  (HYST_SHIFT)
    ) u_thresh (
        .i_min        (trk_min),
        .i_max        (trk_max),
        .i_min_span   (i_cfg.min_span),
        .i_hyst_floor (i_cfg.hyst_floor),
        .o_span       (thr_span),
        .o_no_signal  (thr_no_sig),
        .o_upper      (thr_upper),
        .o_lower      (thr_lower)
    );

    // window counter end test, zero length acts as one
    always_comb begin
        cnt_inc  = r_cnt + 1'b1;
        lim_sel  = (r_phase == PH_MEAS) ? i_cfg.meas_samples : i_cfg.cal_samples;
        lim      = (lim_sel == '0) ? CNT_W'(1) : lim_sel;
        win_done = (cnt_inc == '0) || (cnt_inc >= lim);
        v_t      = TW'(i_sample);
    end

    // next phase
    always_comb begin
        case (r_phase)
            PH_INIT: begin
                n_phase = PH_MEAS;
            end
            PH_MEAS: begin
                n_phase = win_done ? PH_CAL : PH_MEAS;
            end
            default: begin
                n_phase = (win_done && !thr_no_sig) ? PH_INIT : PH_CAL;
            end
        endcase
    end

    // datapath next values and result
    always_comb begin
        n_cnt      = cnt_inc;
        n_min      = trk_min;
        n_max      = trk_max;
        n_upper    = r_upper;
        n_lower    = r_lower;
        n_below    = r_below;
        n_tally    = r_tally;
        res_now    = 1'b0;
        res_status = 1'b0;
        res_count  = '0;
        res_freq   = '0;
        case (r_phase)
            PH_INIT: begin
                n_below = v_t < r_lower;
                n_tally = '0;
                n_cnt   = '0;
            end
            PH_MEAS: begin
                if (r_below) begin
                    if (v_t > r_upper) begin
                        if (r_tally != TALLY_MAX) begin
                            n_tally = r_tally + 1'b1;
                        end
                        n_below = 1'b0;
                    end
                end else if (v_t < r_lower) begin
                    n_below = 1'b1;
                end
                if (win_done) begin
                    res_now   = 1'b1;
                    res_count = n_tally;
                    res_freq  = FREQ_W'(n_tally) * FREQ_W'(i_cfg.hz_per_edge_q4);
                    n_cnt     = '0;
                    n_min     = SAMPLE_MAX;
                    n_max     = '0;
                end
            end
            default: begin
                if (win_done) begin
                    n_cnt = '0;
                    if (thr_no_sig) begin
                        res_now    = 1'b1;
                        res_status = 1'b1;
                        n_min      = SAMPLE_MAX;
                        n_max      = '0;
                    end else begin
                        n_upper = thr_upper;
                        n_lower = thr_lower;
                    end
                end
            end
        endcase
    end

    // take a beat unless its result would overrun a held one
    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        o_in_take = i_in_valid && (out_free || !res_now);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CAL;
            r_cnt   <= '0;
            r_min   <= SAMPLE_MAX;
            r_max   <= '0;
            r_upper <= '0;
            r_lower <= '0;
            r_below <= 1'b0;
            r_tally <= '0;
        end else if (o_in_take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_min   <= n_min;
            r_max   <= n_max;
            r_upper <= n_upper;
            r_lower <= n_lower;
            r_below <= n_below;
            r_tally <= n_tally;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_take && res_now) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (o_in_take && res_now) begin
            r_out_status <= res_status;
            r_out_count  <= res_count;
            r_out_freq   <= res_freq;
            r_out_span   <= thr_span;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_edge_count = r_out_count;
    assign o_freq_q4    = r_out_freq;
    assign o_span_seen  = r_out_span;

    // a held result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(o_in_take && res_now))
        else $error("result register overwritten while stalled");

    // the settling sample never produces a result
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INIT) |-> !res_now)
        else $error("result produced on settling sample");

    // settling sample always leads into measurement with a cleared tally
    a_init_to_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_take && r_phase == PH_INIT) |=> (r_phase == PH_MEAS && r_tally == '0))
        else $error("settling sample did not start measurement");

    // no-signal results carry no count
    a_nosig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_count == '0 && r_out_freq == '0))
        else $error("no-signal result with nonzero count");

    // every result ends a window and restarts calibration
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_take && res_now) |=> (r_phase == PH_CAL && r_cnt == '0 && r_max == '0))
        else $error("calibration not restarted after result");

endmodule

`default_nettype wire

// File: sv/auto_threshold_frequency_counter.sv
// auto_threshold_frequency_counter: top level with register bank and input stage
// Latency: two register stages, the input stage and then the result register; o_valid rises
// at the clock edge at which the core takes the sample beat ending a window from the input stage.
// Throughput: one sample beat per cycle; the input stage stalls only while a result is
// held in the output register and the next sample would produce another one.
// Reset (synchronous, active low): registers return to their defaults, the block starts
// in calibration with an empty window, and both valid flags clear.
`default_nettype none

module auto_threshold_frequency_counter #(
    parameter int SAMPLE_BITS = atfc_pkg::SAMPLE_BITS_DEF,
    parameter int HYST_SHIFT  = atfc_pkg::HYST_SHIFT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [atfc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [atfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [SAMPLE_BITS-1:0]            i_sample,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_status,
    output logic      [atfc_pkg::CNT_W-1:0]        o_edge_count,
    output logic      [atfc_pkg::FREQ_W-1:0]       o_freq_q4,
    output logic      [SAMPLE_BITS-1:0]            o_span_seen
);
    import atfc_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   core_take;

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_samples    <= CAL_SAMPLES_RST;
            r_cfg.meas_samples   <= MEAS_SAMPLES_RST;
            r_cfg.min_span       <= MIN_SPAN_RST;
            r_cfg.hyst_floor     <= HYST_FLOOR_RST;
            r_cfg.hz_per_edge_q4 <= HZ_PER_EDGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAL_SAMPLES:  r_cfg.cal_samples    <= i_cfg_data[CNT_W-1:0];
                CFG_MEAS_SAMPLES: r_cfg.meas_samples   <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_SPAN:     r_cfg.min_span       <= i_cfg_data[MIN_SPAN_W-1:0];
                CFG_HYST_FLOOR:   r_cfg.hyst_floor     <= i_cfg_data[HYST_FLOOR_W-1:0];
                CFG_HZ_PER_EDGE:  r_cfg.hz_per_edge_q4 <= i_cfg_data[HZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stage holds a beat until the core takes it
    assign o_stall = r_in_valid && !core_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_sample <= i_sample;
        end
    end

    atfc_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .HYST_SHIFT  (HYST_SHIFT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (r_in_valid),
        .i_sample     (r_sample),
        .o_in_take    (core_take),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_status     (o_status),
        .o_edge_count (o_edge_count),
        .o_freq_q4    (o_freq_q4),
        .o_span_seen  (o_span_seen)
    );

endmodule

`default_nettype wire

// File: bench/atfc_reading_checker.sv
// atfc_reading_checker: tracks the frequency counter's sample and result beats and checks each result
`default_nettype none

module atfc_reading_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration writes seen by the block
    input  wire logic                                i_cfg_we,
    input  wire logic [atfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [atfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // sample channel
    input  wire logic                                i_sample_valid,
    input  wire logic                                i_sample_stall,
    input  wire logic [atfc_pkg::SAMPLE_BITS_DEF-1:0] i_sample,
    // result channel
    input  wire logic                                i_result_valid,
    input  wire logic                                i_result_stall,
    input  wire logic                                i_status,
    input  wire logic [atfc_pkg::CNT_W-1:0]          i_edge_count,
    input  wire logic [atfc_pkg::FREQ_W-1:0]         i_freq_q4,
    input  wire logic [atfc_pkg::SAMPLE_BITS_DEF-1:0] i_span_seen,
    // totals for the bench top
    output int                                       o_mismatches,
    output int                                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import atfc_pkg::*;

    localparam int SB    = SAMPLE_BITS_DEF;
    localparam int THR_W = SB + 1;

    // one frequency reading as the block reports it
    typedef struct packed {
        logic                 status;
        logic [CNT_W-1:0]     edge_count;
        logic [FREQ_W-1:0]    freq_q4;
        logic [SB-1:0]        span_seen;
    } t_reading;

    t_reading expected_readings[$];

    // shadow of the block's registers and state
    t_cfg              cfg;
    t_phase            phase;
    logic [CNT_W-1:0]  win_count;
    logic [SB-1:0]     lo_seen;
    logic [SB-1:0]     hi_seen;
    logic [THR_W-1:0]  upper_thr;
    logic [THR_W-1:0]  lower_thr;
    logic              below;
    logic [CNT_W-1:0]  edges;

    int mismatches = 0;

    assign o_mismatches = mismatches;

    // start a fresh calibration window
    function automatic void restart_calibration();
        phase     = PH_CAL;
        win_count = '0;
        lo_seen   = '1;
        hi_seen   = '0;
    endfunction

    // count one sample into the window, true when the window closes
    function automatic bit window_closed(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] lim;
        lim       = (len == '0) ? CNT_W'(1) : len;
        win_count = win_count + 1'b1;
        return (win_count == '0) || (win_count >= lim);
    endfunction

    // advance the counter by one sample; done is set when a reading comes out
    function automatic void advance_counter(input logic [SB-1:0] v, output bit done,
                                            output t_reading rd);
        logic [SB-1:0]    span;
        logic [THR_W-1:0] mid;
        logic [THR_W-1:0] hyst;
        done = 1'b0;
        rd   = '0;
        case (phase)
            PH_INIT: begin
                below     = ({1'b0, v} < lower_thr);
                edges     = '0;
                win_count = '0;
                phase     = PH_MEAS;
            end
            PH_MEAS: begin
                if (below) begin
                    if ({1'b0, v} > upper_thr) begin
                        if (edges != '1)
                            edges = edges + 1'b1;
                        below = 1'b0;
                    end
                end else if ({1'b0, v} < lower_thr) begin
                    below = 1'b1;
                end
                if (window_closed(cfg.meas_samples)) begin
                    done          = 1'b1;
                    rd.status     = 1'b0;
                    rd.edge_count = edges;
                    rd.freq_q4    = FREQ_W'(edges) * FREQ_W'(cfg.hz_per_edge_q4);
                    rd.span_seen  = hi_seen - lo_seen;
                    restart_calibration();
                end
            end
            default: begin
                // calibration, also any stray phase code
                phase = PH_CAL;
                if (v < lo_seen) lo_seen = v;
                if (v > hi_seen) hi_seen = v;
                if (window_closed(cfg.cal_samples)) begin
                    span = hi_seen - lo_seen;
                    if (span < cfg.min_span) begin
                        done         = 1'b1;
                        rd.status    = 1'b1;
                        rd.span_seen = span;
                        restart_calibration();
                    end else begin
                        mid  = ({1'b0, lo_seen} + {1'b0, hi_seen}) >> 1;
                        hyst = THR_W'(span) >> HYST_SHIFT_DEF;
                        if (hyst < THR_W'(cfg.hyst_floor))
                            hyst = THR_W'(cfg.hyst_floor);
                        upper_thr = mid + hyst;
                        lower_thr = (mid > hyst) ? (mid - hyst) : '0;
                        phase     = PH_INIT;
                        win_count = '0;
                    end
                end
            end
        endcase
    endfunction

    // field compare with report
    function automatic void compare_field(input string name, input logic [FREQ_W-1:0] want,
                                          input logic [FREQ_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // watch both channels and the register port at each rising edge
    always @(posedge i_clk) begin : watch
        t_reading got;
        t_reading want;
        t_reading fresh;
        bit       produced;
        if (!i_rst_n) begin
            cfg.cal_samples    = CAL_SAMPLES_RST;
            cfg.meas_samples   = MEAS_SAMPLES_RST;
            cfg.min_span       = MIN_SPAN_RST;
            cfg.hyst_floor     = HYST_FLOOR_RST;
            cfg.hz_per_edge_q4 = HZ_PER_EDGE_RST;
            restart_calibration();
            upper_thr = '0;
            lower_thr = '0;
            below     = 1'b0;
            edges     = '0;
            expected_readings.delete();
        end else begin
            // result beat against the oldest expected reading
            if (i_result_valid && !i_result_stall) begin
                got.status     = i_status;
                got.edge_count = i_edge_count;
                got.freq_q4    = i_freq_q4;
                got.span_seen  = i_span_seen;
                if (expected_readings.size() == 0) begin
                    $error("result beat with no reading expected");
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("status", FREQ_W'(want.status), FREQ_W'(got.status));
                    compare_field("edge_count", FREQ_W'(want.edge_count),
                                  FREQ_W'(got.edge_count));
                    compare_field("freq_q4", want.freq_q4, got.freq_q4);
                    compare_field("span_seen", FREQ_W'(want.span_seen),
                                  FREQ_W'(got.span_seen));
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAL_SAMPLES:  cfg.cal_samples    = i_cfg_data;
                    CFG_MEAS_SAMPLES: cfg.meas_samples   = i_cfg_data;
                    CFG_MIN_SPAN:     cfg.min_span       = i_cfg_data[MIN_SPAN_W-1:0];
                    CFG_HYST_FLOOR:   cfg.hyst_floor     = i_cfg_data[HYST_FLOOR_W-1:0];
                    CFG_HZ_PER_EDGE:  cfg.hz_per_edge_q4 = i_cfg_data[HZ_W-1:0];
                    default: ;
                endcase
            end
            // sample beat through the predictor
            if (i_sample_valid && !i_sample_stall) begin
                advance_counter(i_sample, produced, fresh);
                if (produced)
                    expected_readings.push_back(fresh);
            end
        end
        o_outstanding <= expected_readings.size();
    end

endmodule

`default_nettype wire

// File: bench/auto_threshold_frequency_counter_test.sv
// auto_threshold_frequency_counter_test: stimulus, reset, watchdog and verdict for the frequency counter
`default_nettype none

module auto_threshold_frequency_counter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import atfc_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int FULL_SCALE   = (1 << SB) - 1;

    // waveform families for the random part
    typedef enum int {
        SHAPE_SQUARE,
        SHAPE_RAMP,
        SHAPE_NOISE,
        SHAPE_FLAT
    } t_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [SB-1:0]         i_sample;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_status;
    logic [CNT_W-1:0]      o_edge_count;
    logic [FREQ_W-1:0]     o_freq_q4;
    logic [SB-1:0]         o_span_seen;

    int mismatches;
    int outstanding;
    bit calm;
    int quiet_cycles = 0;

    auto_threshold_frequency_counter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_edge_count (o_edge_count),
        .o_freq_q4    (o_freq_q4),
        .o_span_seen  (o_span_seen)
    );

    atfc_reading_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_valid),
        .i_sample_stall (o_stall),
        .i_sample       (i_sample),
        .i_result_valid (o_valid),
        .i_result_stall (i_stall),
        .i_status       (o_status),
        .i_edge_count   (o_edge_count),
        .i_freq_q4      (o_freq_q4),
        .i_span_seen    (o_span_seen),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 35);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // one sample beat, with random gaps ahead of it; returns at the falling edge after acceptance
    task automatic feed_sample(input logic [SB-1:0] v);
        while (!calm && ($urandom_range(0, 99) < 35)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // one register write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop sampling, let every reading come out and the pipeline empty
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic int clip(input int x);
        return (x < 0) ? 0 : ((x > FULL_SCALE) ? FULL_SCALE : x);
    endfunction

    initial begin
        int     sent;
        int     n;
        int     lo_lvl;
        int     hi_lvl;
        int     period;
        int     amp;
        int     s;
        int     pick;
        t_shape shape;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_stall     = 1'b0;
        calm        = 1'b0;
        sent        = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-scale square wave, widest span, largest factor
        write_reg(CFG_CAL_SAMPLES, 16'd2);
        write_reg(CFG_MEAS_SAMPLES, 16'd4);
        write_reg(CFG_MIN_SPAN, 16'd1023);
        write_reg(CFG_HYST_FLOOR, 16'd0);
        write_reg(CFG_HZ_PER_EDGE, 16'hFFFF);
        feed_sample(0);
        feed_sample(FULL_SCALE);
        feed_sample(0);
        feed_sample(FULL_SCALE);
        feed_sample(0);
        feed_sample(FULL_SCALE);
        feed_sample(0);
        drain_and_settle();

        // no signal, calibration window of zero length
        write_reg(CFG_CAL_SAMPLES, 16'd0);
        feed_sample(512);
        drain_and_settle();

        // lower threshold clipped at zero, then upper threshold past full scale
        write_reg(CFG_CAL_SAMPLES, 16'd2);
        write_reg(CFG_MEAS_SAMPLES, 16'd0);
        write_reg(CFG_MIN_SPAN, 16'd0);
        write_reg(CFG_HYST_FLOOR, 16'd511);
        feed_sample(0);
        feed_sample(20);
        feed_sample(0);
        feed_sample(FULL_SCALE);
        feed_sample(1000);
        feed_sample(FULL_SCALE);
        feed_sample(0);
        feed_sample(FULL_SCALE);
        drain_and_settle();

        // longest windows, then each cut short while it is running
        write_reg(CFG_CAL_SAMPLES, 16'hFFFF);
        write_reg(CFG_MEAS_SAMPLES, 16'hFFFF);
        write_reg(CFG_MIN_SPAN, 16'd10);
        write_reg(CFG_HYST_FLOOR, 16'd2);
        write_reg(CFG_HZ_PER_EDGE, 16'd0);
        feed_sample(100);
        feed_sample(900);
        feed_sample(300);
        drain_and_settle();
        write_reg(CFG_CAL_SAMPLES, 16'd2);
        feed_sample(500);
        feed_sample(100);
        feed_sample(700);
        feed_sample(100);
        feed_sample(700);
        drain_and_settle();
        write_reg(CFG_MEAS_SAMPLES, 16'd1);
        feed_sample(100);
        drain_and_settle();

        // random rounds: new settings, then a waveform with random content
        while (sent < RANDOM_ITEMS) begin
            drain_and_settle();
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_CAL_SAMPLES,
                          ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_MEAS_SAMPLES,
                          ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 30)));
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                write_reg(CFG_MIN_SPAN, (pick == 0) ? 16'd1023 :
                          (pick == 1) ? 16'($urandom_range(0, 1023)) :
                          16'($urandom_range(0, 60)));
            end
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                write_reg(CFG_HYST_FLOOR, (pick == 0) ? 16'd511 :
                          (pick == 1) ? 16'($urandom_range(0, 511)) :
                          16'($urandom_range(0, 40)));
            end
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_HZ_PER_EDGE, 16'($urandom_range(0, 65535)));

            pick   = $urandom_range(0, 99);
            shape  = (pick < 60) ? SHAPE_SQUARE : (pick < 75) ? SHAPE_RAMP :
                     (pick < 90) ? SHAPE_NOISE : SHAPE_FLAT;
            n      = $urandom_range(10, 60);
            lo_lvl = $urandom_range(0, FULL_SCALE);
            hi_lvl = $urandom_range(0, FULL_SCALE);
            period = $urandom_range(2, 12);
            amp    = $urandom_range(0, 8);

            for (int k = 0; k < n; k++) begin
                case (shape)
                    SHAPE_SQUARE: begin
                        s = ((k % period) < (period / 2)) ? lo_lvl : hi_lvl;
                        s = s + int'($urandom_range(0, 2 * amp)) - amp;
                    end
                    SHAPE_RAMP:  s = lo_lvl + ((hi_lvl - lo_lvl) * (k % period)) / period;
                    SHAPE_NOISE: s = $urandom_range(0, FULL_SCALE);
                    default:     s = lo_lvl + int'($urandom_range(0, amp));
                endcase
                feed_sample(clip(s));
                sent++;
                // a stretch with no idling on either side
                calm = (sent >= 150) && (sent < 260);
            end
        end

        // wait for the last readings and let the pipeline run dry
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
